[hdl/adaptive_replacement_cache_unit_macros.svh]
// Assertion macros shared by the cache unit.
`ifndef ADAPTIVE_REPLACEMENT_CACHE_UNIT_MACROS_SVH
`define ADAPTIVE_REPLACEMENT_CACHE_UNIT_MACROS_SVH

// Check an implication at every clock edge outside reset.
`define ARCU_CHK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cache unit check failed");

// Check a condition that must always hold outside reset.
`define ARCU_CHK_ALW(lbl, cons) `ARCU_CHK_IMP(lbl, 1'b1, cons)

`endif

[hdl/arcu_pkg.sv]
// Package: list codes and register map of the cache unit.
package arcu_pkg;

    // Recency lists a slot can belong to
    typedef enum logic [1:0] {
        L_T1 = 2'd0,
        L_T2 = 2'd1,
        L_B1 = 2'd2,
        L_B2 = 2'd3
    } t_list;

    // Register indexes
    localparam logic REG_CAPACITY = 1'b0;

    // Bits of the capacity field in a write
    localparam int CAP_FIELD_BITS = 5;

endpackage

[hdl/arcu_if.sv]
// Request and response channel interfaces of the cache unit.
interface arcu_req_if #(
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32
) ();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] write_value;

    modport source (output valid, kind, key, write_value, input ready);
    modport sink   (input valid, kind, key, write_value, output ready);
endinterface

interface arcu_rsp_if #(
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32
) ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [DATA_BITS-1:0] read_value;
    logic                 evicted_valid;
    logic [KEY_BITS-1:0]  victim_key;

    modport source (output valid, hit, read_value, evicted_valid, victim_key, input ready);
    modport sink   (input valid, hit, read_value, evicted_valid, victim_key, output ready);
endinterface

[hdl/arcu_ram.sv]
// Generic simple dual-port RAM with registered read.
module arcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/arcu_div.sv]
// Restoring divider, one quotient bit per cycle.
module arcu_div #(
    parameter int W = 5
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot
);
    localparam int CNW = $clog2(W + 1);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic [W-1:0]   r_a, n_a;
    logic [W-1:0]   r_r, n_r;
    logic [W-1:0]   r_b, n_b;
    logic [W:0]     shifted;
    logic [W:0]     diff;
    logic           ge;
    logic [W:0]     qtmp;

    // One shift and trial subtract per cycle
    always_comb begin
        shifted = {r_r, r_a[W-1]};
        ge      = shifted >= {1'b0, r_b};
        diff    = shifted - {1'b0, r_b};
        qtmp    = {r_a, ge};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_r     = r_r;
        n_b     = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_dividend;
            n_r    = '0;
            n_b    = i_divisor;
        end else if (r_busy) begin
            n_a   = qtmp[W-1:0];
            n_r   = ge ? diff[W-1:0] : shifted[W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNW'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_r <= n_r;
        r_b <= n_b;
    end

    assign o_done = r_done;
    assign o_quot = r_a;
endmodule

[hdl/adaptive_replacement_cache_unit.sv]
// Top level: adaptive replacement cache with a slot-sweeping sequencer.
//
//   channel   direction  transfer rule           contents
//   i_req     in         valid && ready          kind, key, write_value
//   o_rsp     out        valid && ready          hit, read_value, evicted_valid, victim_key
//   apb cfg   in         psel penable pwrite     capacity at address 0
//
// Every request sweeps all 3*MAX_CAPACITY slots of the slot RAM once;
// further sweeps follow for each unlink: a hit takes two sweeps, a ghost hit a divide
// and up to three more sweeps, a new key up to two more sweeps. The single RAM read
// port serves every sweep. Reset is synchronous; valid bits clear at once, so no sweep
// follows reset. i_req.ready is high only when idle; a result waits in the output
// register while the next item is taken, and a finished item stalls until it drains.
module adaptive_replacement_cache_unit
    import arcu_pkg::*;
#(
    parameter int MAX_CAPACITY = 16,
    parameter int KEY_BITS     = 32,
    parameter int DATA_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    arcu_req_if.sink    i_req,
    arcu_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    `include "adaptive_replacement_cache_unit_macros.svh"

    localparam int NSLOT = 3 * MAX_CAPACITY;
    localparam int SW    = $clog2(NSLOT);
    localparam int IW    = $clog2(NSLOT + 1);
    localparam int CW    = $clog2(MAX_CAPACITY + 1);
    localparam int WW    = 2 + CW + KEY_BITS + DATA_BITS;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PASS   = 6'b000010,
        S_DIV    = 6'b000100,
        S_DECIDE = 6'b001000,
        S_APPEND = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        PH_SCAN  = 3'd0,
        PH_HIT   = 3'd1,
        PH_GHOST = 3'd2,
        PH_DROP  = 3'd3,
        PH_MOVE  = 3'd4
    } t_phase;

    // Control state
    t_state               r_state, n_state;
    t_phase               r_phase, n_phase;
    logic [IW-1:0]        r_idx, n_idx;
    logic                 r_rd_vld, n_rd_vld;
    logic [SW-1:0]        r_rd_idx, n_rd_idx;
    logic [NSLOT-1:0]     r_valid, n_valid;
    logic [3:0][CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]        r_p, n_p;
    logic [CW-1:0]        r_cap, n_cap;
    logic                 r_rsp_vld, n_rsp_vld;
    logic                 r_div_go, n_div_go;
    logic [3:0]           r_lru_ok, n_lru_ok;
    logic                 r_free_ok, n_free_ok;
    logic                 r_s_ok, n_s_ok;

    // Item and sweep payload
    logic                 r_kind, n_kind;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [DATA_BITS-1:0] r_wdata, n_wdata;
    t_list                r_c_list, n_c_list;
    logic [CW-1:0]        r_c_rank, n_c_rank;
    logic [SW-1:0]        r_c_tgt, n_c_tgt;
    logic                 r_c_tgt_en, n_c_tgt_en;
    logic                 r_c_mv, n_c_mv;
    t_list                r_c_mv_list, n_c_mv_list;
    logic [CW-1:0]        r_c_mv_rank, n_c_mv_rank;
    logic                 r_c_wd_en, n_c_wd_en;
    logic [3:0][SW-1:0]   r_lru, n_lru;
    logic [SW-1:0]        r_free, n_free;
    logic [SW-1:0]        r_s_idx, n_s_idx;
    t_list                r_s_list, n_s_list;
    logic [CW-1:0]        r_s_rank, n_s_rank;
    logic [DATA_BITS-1:0] r_s_data, n_s_data;
    logic                 r_ghost, n_ghost;
    logic                 r_in_b2, n_in_b2;
    t_list                r_dem, n_dem;
    logic                 r_o_hit, n_o_hit;
    logic [DATA_BITS-1:0] r_o_rdv, n_o_rdv;
    logic                 r_o_ev, n_o_ev;
    logic [KEY_BITS-1:0]  r_o_evkey, n_o_evkey;
    logic                 r_rsp_hit, n_rsp_hit;
    logic [DATA_BITS-1:0] r_rsp_rdv, n_rsp_rdv;
    logic                 r_rsp_ev, n_rsp_ev;
    logic [KEY_BITS-1:0]  r_rsp_evkey, n_rsp_evkey;

    // RAM port and sweep element signals
    logic                 ram_we;
    logic [SW-1:0]        ram_waddr;
    logic [WW-1:0]        ram_wdata;
    logic [WW-1:0]        ram_rdata;
    t_list                pre_list;
    logic [CW-1:0]        pre_rank;
    logic [KEY_BITS-1:0]  pre_key;
    logic [DATA_BITS-1:0] pre_data;
    logic                 pre_valid;
    logic                 is_tgt, is_dec;
    logic                 post_valid;
    t_list                post_list;
    logic [CW-1:0]        post_rank;
    logic [DATA_BITS-1:0] post_data;

    // Decision helpers
    logic                 div_done;
    logic [CW-1:0]        div_quot;
    logic [CW-1:0]        div_a, div_b;
    logic [CW-1:0]        d_step;
    logic [CW:0]          p_sum;
    logic                 cfg_we;
    logic [CAP_FIELD_BITS-1:0] cfg_v;
    logic [CW:0]          res_sum;
    t_list                dem_l, dem_g, from_l;
    logic                 dem_req, dem_none;
    logic                 mv_go;
    t_list                app_list;

    arcu_ram #(.WIDTH(WW), .DEPTH(NSLOT)) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[SW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign div_a = r_in_b2 ? r_cnt[L_B1] : r_cnt[L_B2];
    assign div_b = r_in_b2 ? r_cnt[L_B2] : r_cnt[L_B1];

    arcu_div #(.W(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Decode the slot word under the sweep and work out its new contents
    always_comb begin
        pre_data  = ram_rdata[DATA_BITS-1:0];
        pre_key   = ram_rdata[DATA_BITS +: KEY_BITS];
        pre_rank  = ram_rdata[DATA_BITS + KEY_BITS +: CW];
        pre_list  = t_list'(ram_rdata[WW-1 -: 2]);
        pre_valid = r_valid[r_rd_idx];
        is_tgt    = r_c_tgt_en && (r_rd_idx == r_c_tgt);
        is_dec    = pre_valid && (pre_list == r_c_list) && (pre_rank > r_c_rank);
        post_valid = pre_valid;
        post_list  = pre_list;
        post_rank  = pre_rank;
        post_data  = pre_data;
        if (is_tgt) begin
            post_valid = r_c_mv;
            if (r_c_mv) begin
                post_list = r_c_mv_list;
                post_rank = r_c_mv_rank;
                if (r_c_wd_en) begin
                    post_data = r_wdata;
                end
            end
        end else if (is_dec) begin
            post_rank = pre_rank - 1'b1;
        end
    end

    // Capacity register write with clamping
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign cfg_v  = pwdata[CAP_FIELD_BITS-1:0];
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(r_cap) : 32'd0;

    assign d_step  = (div_b == '0 || div_quot == '0) ? CW'(1) : div_quot;
    assign p_sum   = {1'b0, r_p} + {1'b0, d_step};
    assign res_sum = {1'b0, r_cnt[L_T1]} + {1'b0, r_cnt[L_T2]};

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_valid     = r_valid;
        n_cnt       = r_cnt;
        n_p         = r_p;
        n_cap       = r_cap;
        n_rsp_vld   = r_rsp_vld;
        n_div_go    = 1'b0;
        n_lru_ok    = r_lru_ok;
        n_free_ok   = r_free_ok;
        n_s_ok      = r_s_ok;
        n_kind      = r_kind;
        n_key       = r_key;
        n_wdata     = r_wdata;
        n_c_list    = r_c_list;
        n_c_rank    = r_c_rank;
        n_c_tgt     = r_c_tgt;
        n_c_tgt_en  = r_c_tgt_en;
        n_c_mv      = r_c_mv;
        n_c_mv_list = r_c_mv_list;
        n_c_mv_rank = r_c_mv_rank;
        n_c_wd_en   = r_c_wd_en;
        n_lru       = r_lru;
        n_free      = r_free;
        n_s_idx     = r_s_idx;
        n_s_list    = r_s_list;
        n_s_rank    = r_s_rank;
        n_s_data    = r_s_data;
        n_ghost     = r_ghost;
        n_in_b2     = r_in_b2;
        n_dem       = r_dem;
        n_o_hit     = r_o_hit;
        n_o_rdv     = r_o_rdv;
        n_o_ev      = r_o_ev;
        n_o_evkey   = r_o_evkey;
        n_rsp_hit   = r_rsp_hit;
        n_rsp_rdv   = r_rsp_rdv;
        n_rsp_ev    = r_rsp_ev;
        n_rsp_evkey = r_rsp_evkey;
        ram_we      = 1'b0;
        ram_waddr   = r_rd_idx;
        ram_wdata   = {post_list, post_rank, pre_key, post_data};
        dem_l       = L_T1;
        dem_req     = 1'b0;
        dem_none    = 1'b0;
        from_l      = L_T1;
        mv_go       = 1'b0;
        dem_g       = L_B1;
        app_list    = L_T1;

        // Drain the output register
        if (r_rsp_vld && o_rsp.ready) begin
            n_rsp_vld = 1'b0;
        end

        if (cfg_we) begin
            if (cfg_v == '0) begin
                n_cap = CW'(1);
            end else if (int'(cfg_v) > MAX_CAPACITY) begin
                n_cap = CW'(MAX_CAPACITY);
            end else begin
                n_cap = CW'(cfg_v);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_kind     = i_req.kind;
                    n_key      = i_req.key;
                    n_wdata    = i_req.write_value;
                    n_o_hit    = 1'b0;
                    n_o_rdv    = '0;
                    n_o_ev     = 1'b0;
                    n_o_evkey  = '0;
                    n_s_ok     = 1'b0;
                    n_c_list   = L_T1;
                    n_c_rank   = '1;
                    n_c_tgt_en = 1'b0;
                    n_phase    = PH_SCAN;
                    n_idx      = '0;
                    n_lru_ok   = '0;
                    n_free_ok  = 1'b0;
                    n_state    = S_PASS;
                end
            end
            S_PASS: begin
                // Issue the next slot read
                if (r_idx != IW'(NSLOT)) begin
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[SW-1:0];
                end else if (!r_rd_vld) begin
                    n_state = S_DECIDE;
                end
                // Update the slot read last cycle and track list ends
                if (r_rd_vld) begin
                    ram_we             = is_tgt || is_dec;
                    n_valid[r_rd_idx]  = post_valid;
                    if (post_valid && post_rank == '0) begin
                        n_lru[post_list]    = r_rd_idx;
                        n_lru_ok[post_list] = 1'b1;
                    end
                    if (!post_valid && !n_free_ok) begin
                        n_free    = r_rd_idx;
                        n_free_ok = 1'b1;
                    end
                    if (r_phase == PH_SCAN && pre_valid && pre_key == r_key && !r_s_ok) begin
                        n_s_ok   = 1'b1;
                        n_s_idx  = r_rd_idx;
                        n_s_list = pre_list;
                        n_s_rank = pre_rank;
                        n_s_data = pre_data;
                    end
                    if (is_tgt && r_phase == PH_MOVE) begin
                        n_o_evkey = pre_key;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    // Adapt the target, then unlink the key from its ghost list
                    if (!r_in_b2) begin
                        n_p = (p_sum > {1'b0, r_cap}) ? r_cap : p_sum[CW-1:0];
                    end else begin
                        n_p = (r_p > d_step) ? (r_p - d_step) : '0;
                    end
                    if (r_cnt[r_s_list] != '0) begin
                        n_cnt[r_s_list] = r_cnt[r_s_list] - 1'b1;
                    end
                    n_c_list   = r_s_list;
                    n_c_rank   = r_s_rank;
                    n_c_tgt    = r_s_idx;
                    n_c_tgt_en = 1'b1;
                    n_c_mv     = 1'b0;
                    n_phase    = PH_GHOST;
                    n_idx      = '0;
                    n_lru_ok   = '0;
                    n_free_ok  = 1'b0;
                    n_state    = S_PASS;
                end
            end
            S_DECIDE: begin
                case (r_phase)
                    PH_SCAN: begin
                        if (r_s_ok && (r_s_list == L_T1 || r_s_list == L_T2)) begin
                            // Resident hit: move the key to the MRU end of T2
                            n_o_hit = 1'b1;
                            n_o_rdv = r_kind ? '0 : r_s_data;
                            if (r_cnt[r_s_list] != '0) begin
                                n_cnt[r_s_list] = r_cnt[r_s_list] - 1'b1;
                            end
                            n_c_mv_rank    = n_cnt[L_T2];
                            n_cnt[L_T2]    = n_cnt[L_T2] + 1'b1;
                            n_c_list       = r_s_list;
                            n_c_rank       = r_s_rank;
                            n_c_tgt        = r_s_idx;
                            n_c_tgt_en     = 1'b1;
                            n_c_mv         = 1'b1;
                            n_c_mv_list    = L_T2;
                            n_c_wd_en      = r_kind;
                            n_phase        = PH_HIT;
                            n_idx          = '0;
                            n_lru_ok       = '0;
                            n_free_ok      = 1'b0;
                            n_state        = S_PASS;
                        end else if (!r_kind) begin
                            n_state = S_DONE;
                        end else if (r_s_ok) begin
                            n_ghost  = 1'b1;
                            n_in_b2  = (r_s_list == L_B2);
                            n_div_go = 1'b1;
                            n_state  = S_DIV;
                        end else begin
                            n_ghost = 1'b0;
                            if (res_sum >= {1'b0, r_cap}) begin
                                from_l = (r_cnt[L_T1] > r_p) ? L_T1 : L_T2;
                                if (r_cnt[from_l] == '0) begin
                                    from_l = (from_l == L_T1) ? L_T2 : L_T1;
                                end
                                dem_l   = from_l;
                                dem_req = 1'b1;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end
                    end
                    PH_GHOST: begin
                        // Pick the resident list that gives up its LRU entry
                        if (r_cnt[L_T1] != '0 && (r_cnt[L_T1] > r_p
                                || (r_in_b2 && r_cnt[L_T1] == r_p))) begin
                            dem_l = L_T1;
                        end else if (r_cnt[L_T2] != '0) begin
                            dem_l = L_T2;
                        end else if (r_cnt[L_T1] != '0) begin
                            dem_l = L_T1;
                        end else begin
                            dem_none = 1'b1;
                        end
                        if (dem_none) begin
                            n_state = S_APPEND;
                        end else begin
                            dem_req = 1'b1;
                        end
                    end
                    PH_DROP: begin
                        mv_go = 1'b1;
                    end
                    PH_MOVE: begin
                        n_state = S_APPEND;
                    end
                    PH_HIT: begin
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase

                // Start a demotion: drop the ghost LRU first if that list is full
                if (dem_req) begin
                    n_dem = dem_l;
                    dem_g = t_list'({1'b1, dem_l[0]});
                    if (!r_lru_ok[dem_l]) begin
                        n_state = S_APPEND;
                    end else if (r_cnt[dem_g] >= r_cap && r_lru_ok[dem_g]) begin
                        if (r_cnt[dem_g] != '0) begin
                            n_cnt[dem_g] = r_cnt[dem_g] - 1'b1;
                        end
                        n_c_list   = dem_g;
                        n_c_rank   = '0;
                        n_c_tgt    = r_lru[dem_g];
                        n_c_tgt_en = 1'b1;
                        n_c_mv     = 1'b0;
                        n_phase    = PH_DROP;
                        n_idx      = '0;
                        n_lru_ok   = '0;
                        n_free_ok  = 1'b0;
                        n_state    = S_PASS;
                    end else begin
                        mv_go = 1'b1;
                    end
                end

                // Move the resident LRU entry into its ghost list
                if (mv_go) begin
                    dem_l = dem_req ? dem_l : r_dem;
                    dem_g = t_list'({1'b1, dem_l[0]});
                    n_c_mv_rank = n_cnt[dem_g];
                    n_cnt[dem_g] = n_cnt[dem_g] + 1'b1;
                    if (r_cnt[dem_l] != '0) begin
                        n_cnt[dem_l] = r_cnt[dem_l] - 1'b1;
                    end
                    n_o_ev      = 1'b1;
                    n_c_list    = dem_l;
                    n_c_rank    = '0;
                    n_c_tgt     = r_lru[dem_l];
                    n_c_tgt_en  = 1'b1;
                    n_c_mv      = 1'b1;
                    n_c_mv_list = dem_g;
                    n_c_wd_en   = 1'b0;
                    n_phase     = PH_MOVE;
                    n_idx       = '0;
                    n_lru_ok    = '0;
                    n_free_ok   = 1'b0;
                    n_state     = S_PASS;
                end
            end
            S_APPEND: begin
                // Place the key at the MRU end of T2 (ghost) or T1 (new)
                app_list  = r_ghost ? L_T2 : L_T1;
                ram_waddr = r_ghost ? r_s_idx : r_free;
                ram_wdata = {app_list, r_cnt[app_list], r_key, r_wdata};
                if (r_ghost || r_free_ok) begin
                    ram_we              = 1'b1;
                    n_valid[ram_waddr]  = 1'b1;
                    n_cnt[app_list]     = r_cnt[app_list] + 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hand the result over once the output register is free
                if (!r_rsp_vld || o_rsp.ready) begin
                    n_rsp_vld   = 1'b1;
                    n_rsp_hit   = r_o_hit;
                    n_rsp_rdv   = r_o_rdv;
                    n_rsp_ev    = r_o_ev;
                    n_rsp_evkey = r_o_ev ? r_o_evkey : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_SCAN;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_valid   <= '0;
            r_cnt     <= '0;
            r_p       <= '0;
            r_cap     <= CW'(MAX_CAPACITY);
            r_rsp_vld <= 1'b0;
            r_div_go  <= 1'b0;
            r_lru_ok  <= '0;
            r_free_ok <= 1'b0;
            r_s_ok    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_valid   <= n_valid;
            r_cnt     <= n_cnt;
            r_p       <= n_p;
            r_cap     <= n_cap;
            r_rsp_vld <= n_rsp_vld;
            r_div_go  <= n_div_go;
            r_lru_ok  <= n_lru_ok;
            r_free_ok <= n_free_ok;
            r_s_ok    <= n_s_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_kind      <= n_kind;
        r_key       <= n_key;
        r_wdata     <= n_wdata;
        r_c_list    <= n_c_list;
        r_c_rank    <= n_c_rank;
        r_c_tgt     <= n_c_tgt;
        r_c_tgt_en  <= n_c_tgt_en;
        r_c_mv      <= n_c_mv;
        r_c_mv_list <= n_c_mv_list;
        r_c_mv_rank <= n_c_mv_rank;
        r_c_wd_en   <= n_c_wd_en;
        r_lru       <= n_lru;
        r_free      <= n_free;
        r_s_idx     <= n_s_idx;
        r_s_list    <= n_s_list;
        r_s_rank    <= n_s_rank;
        r_s_data    <= n_s_data;
        r_ghost     <= n_ghost;
        r_in_b2     <= n_in_b2;
        r_dem       <= n_dem;
        r_o_hit     <= n_o_hit;
        r_o_rdv     <= n_o_rdv;
        r_o_ev      <= n_o_ev;
        r_o_evkey   <= n_o_evkey;
        r_rsp_hit   <= n_rsp_hit;
        r_rsp_rdv   <= n_rsp_rdv;
        r_rsp_ev    <= n_rsp_ev;
        r_rsp_evkey <= n_rsp_evkey;
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_rsp_vld;
    assign o_rsp.hit           = r_rsp_hit;
    assign o_rsp.read_value    = r_rsp_rdv;
    assign o_rsp.evicted_valid = r_rsp_ev;
    assign o_rsp.victim_key    = r_rsp_evkey;

    // Resident lists never hold more than the largest capacity
    `ARCU_CHK_ALW(a_res_bound, res_sum <= (CW + 1)'(MAX_CAPACITY))
    // A result never reports both a hit and a demotion
    `ARCU_CHK_IMP(a_hit_no_evict, o_rsp.valid && o_rsp.evicted_valid, !o_rsp.hit)
    // The sweep is never running while new items are taken
    `ARCU_CHK_IMP(a_ready_no_sweep, i_req.ready, !r_rd_vld && !r_div_go)
endmodule

[bench/tb_arcu_scoreboard.sv]
// Scoreboard for the cache unit: predicts each response and checks it.
`timescale 1ns / 100ps

class arcu_scoreboard;
    // one slot of the predicted cache state
    typedef struct {
        bit          valid;
        bit [1:0]    list;
        int unsigned rank;
        bit [31:0]   key;
        bit [31:0]   data;
    } t_slot;

    // one expected response
    typedef struct {
        bit        hit;
        bit [31:0] read_value;
        bit        evicted_valid;
        bit [31:0] victim_key;
    } t_rsp;

    localparam int NSLOTS = 48;
    localparam int CAP_MAX = 16;

    t_slot       slots[NSLOTS];
    int unsigned cnt[4];
    int unsigned target;
    int unsigned cap;
    t_rsp        pending_rsp[$];
    int unsigned fail_count;
    int unsigned hits_seen;
    int unsigned evicts_seen;
    int unsigned checked;

    function new();
        foreach (slots[i]) slots[i] = '{0, 0, 0, 0, 0};
        foreach (cnt[i]) cnt[i] = 0;
        target = 0;
        cap = CAP_MAX;
        fail_count = 0;
        hits_seen = 0;
        evicts_seen = 0;
        checked = 0;
    endfunction

    // apply a capacity write with clamping
    function void set_capacity(bit [31:0] v);
        int unsigned c;
        c = 32'(v[4:0]);
        if (c < 1) c = 1;
        if (c > CAP_MAX) c = CAP_MAX;
        cap = c;
    endfunction

    function int find_key(bit [31:0] k);
        foreach (slots[i]) if (slots[i].valid && slots[i].key == k) return i;
        return -1;
    endfunction

    function int find_lru(bit [1:0] l);
        foreach (slots[i])
            if (slots[i].valid && slots[i].list == l && slots[i].rank == 0) return i;
        return -1;
    endfunction

    function void unlink(int s);
        bit [1:0] l;
        l = slots[s].list;
        foreach (slots[i])
            if (slots[i].valid && slots[i].list == l && slots[i].rank > slots[s].rank)
                slots[i].rank--;
        if (cnt[l] > 0) cnt[l]--;
        slots[s].valid = 0;
    endfunction

    function void link(int s, bit [1:0] l);
        slots[s].list = l;
        slots[s].rank = cnt[l];
        cnt[l]++;
        slots[s].valid = 1;
    endfunction

    // move LRU of a resident list to its ghost list
    function int demote(bit [1:0] l);
        bit [1:0] g;
        int s;
        int d;
        g = l + 2'd2;
        s = find_lru(l);
        if (s < 0) return -1;
        if (cnt[g] >= cap) begin
            d = find_lru(g);
            if (d >= 0) unlink(d);
        end
        unlink(s);
        link(s, g);
        return s;
    endfunction

    // note an accepted request and queue its expected response
    function void note_request(bit kind, bit [31:0] k, bit [31:0] v);
        t_rsp r;
        int s;
        int ev;
        int ns;
        int unsigned d;
        bit in_b2;
        bit [1:0] from;
        r = '{0, 0, 0, 0};
        ev = -1;
        s = find_key(k);
        if (s >= 0 && slots[s].list <= arcu_pkg::L_T2) begin
            r.hit = 1;
            if (!kind) r.read_value = slots[s].data;
            else slots[s].data = v;
            unlink(s);
            link(s, arcu_pkg::L_T2);
        end else if (kind) begin
            if (s >= 0) begin
                in_b2 = (slots[s].list == arcu_pkg::L_B2);
                if (!in_b2) begin
                    d = cnt[arcu_pkg::L_B1] ? cnt[arcu_pkg::L_B2] / cnt[arcu_pkg::L_B1] : 0;
                    if (d < 1) d = 1;
                    target = (target + d > cap) ? cap : target + d;
                end else begin
                    d = cnt[arcu_pkg::L_B2] ? cnt[arcu_pkg::L_B1] / cnt[arcu_pkg::L_B2] : 0;
                    if (d < 1) d = 1;
                    target = (target > d) ? target - d : 0;
                end
                unlink(s);
                if (cnt[arcu_pkg::L_T1] >= 1 && (cnt[arcu_pkg::L_T1] > target
                        || (in_b2 && cnt[arcu_pkg::L_T1] == target)))
                    ev = demote(arcu_pkg::L_T1);
                else if (cnt[arcu_pkg::L_T2] >= 1)
                    ev = demote(arcu_pkg::L_T2);
                else if (cnt[arcu_pkg::L_T1] >= 1)
                    ev = demote(arcu_pkg::L_T1);
                slots[s].key = k;
                slots[s].data = v;
                link(s, arcu_pkg::L_T2);
            end else begin
                if (cnt[arcu_pkg::L_T1] + cnt[arcu_pkg::L_T2] >= cap) begin
                    from = (cnt[arcu_pkg::L_T1] > target) ? arcu_pkg::L_T1 : arcu_pkg::L_T2;
                    if (cnt[from] == 0)
                        from = (from == arcu_pkg::L_T1) ? arcu_pkg::L_T2 : arcu_pkg::L_T1;
                    ev = demote(from);
                end
                ns = -1;
                foreach (slots[i]) if (ns < 0 && !slots[i].valid) ns = i;
                if (ns >= 0) begin
                    slots[ns].key = k;
                    slots[ns].data = v;
                    link(ns, arcu_pkg::L_T1);
                end
            end
            if (ev >= 0) begin
                r.evicted_valid = 1;
                r.victim_key = slots[ev].key;
            end
        end
        pending_rsp.push_back(r);
    endfunction

    function void report(string what, bit [31:0] got, bit [31:0] want);
        $display("[%0t] response %0d: %s got %h want %h", $time, checked, what, got, want);
        fail_count++;
    endfunction

    // compare an accepted response with the oldest expectation
    function void check_response(bit hit, bit [31:0] rv, bit evv, bit [31:0] evk);
        t_rsp e;
        if (pending_rsp.size() == 0) begin
            $display("[%0t] response with nothing pending", $time);
            fail_count++;
            return;
        end
        e = pending_rsp.pop_front();
        if (hit != e.hit) report("hit", hit, e.hit);
        if (rv != e.read_value) report("read_value", rv, e.read_value);
        if (evv != e.evicted_valid) report("evicted_valid", evv, e.evicted_valid);
        if (evk != e.victim_key) report("victim_key", evk, e.victim_key);
        hits_seen += e.hit;
        evicts_seen += e.evicted_valid;
        checked++;
    endfunction
endclass

[bench/tb_top.sv]
// Top of the cache unit testbench: stimulus, configuration and response checking.
`timescale 1ns / 100ps

module tb_top;
    import arcu_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    arcu_req_if req_ch ();
    arcu_rsp_if rsp_ch ();

    adaptive_replacement_cache_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    arcu_scoreboard sb = new();
    bit          busy_free = 0;   // stretch with no idling on either side
    int unsigned idle_cycles = 0;
    int unsigned sent = 0;
    bit [31:0]   key_pool[8];

    always #6 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 0;
        req_ch.kind = 0;
        req_ch.key = 0;
        req_ch.write_value = 0;
        rsp_ch.ready = 0;
    end

    // Sink: random stalls, check each accepted response
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted_valid,
                              rsp_ch.victim_key);
        rsp_ch.ready <= busy_free || ($urandom_range(99) >= 18);
    end

    // Watchdog: count cycles with no handshake
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Timeout waiting for a handshake");
            $display("Mismatches found");
            $finish;
        end
    end

    // Write the capacity register with a setup phase and then an access phase
    task automatic write_capacity(bit [31:0] v);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 0; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_capacity(v);
    endtask

    // Send one request and hold it until accepted; valid drops only while idling
    task automatic send_request(bit kind, bit [31:0] k, bit [31:0] v);
        while (!busy_free && $urandom_range(99) < 18) begin
            req_ch.valid <= 0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.kind <= kind;
        req_ch.key <= k;
        req_ch.write_value <= v;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(kind, k, v);
        sent++;
    endtask

    // Wait for all responses and let the block go quiet
    task automatic drain();
        req_ch.valid <= 0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    // Mostly keys from a small pool so hits and ghost hits happen
    task automatic random_phase(int n, int pool_span);
        int unsigned sel;
        bit [31:0] k;
        repeat (n) begin
            sel = $urandom_range(99);
            if (sel < 85) k = key_pool[0] + $urandom_range(pool_span - 1);
            else k = $urandom;
            send_request($urandom_range(99) < 55, k, $urandom);
        end
    endtask

    initial begin
        foreach (key_pool[i]) key_pool[i] = $urandom;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extreme keys and values, miss, hits, update, ghost hits
        send_request(0, 32'h0, 0);
        send_request(1, 32'h0, 32'hFFFF_FFFF);
        send_request(1, 32'hFFFF_FFFF, 32'h0);
        send_request(0, 32'h0, 0);
        send_request(1, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_request(0, 32'hFFFF_FFFF, 0);
        drain();
        write_capacity(2);
        send_request(1, 32'h10, 1);
        send_request(1, 32'h11, 2);
        send_request(1, 32'h12, 3);
        send_request(1, 32'h13, 4);
        send_request(0, 32'h10, 0);
        send_request(1, 32'h10, 5);
        send_request(1, 32'h0, 6);
        send_request(1, 32'h12, 7);
        send_request(0, 32'h12, 0);
        send_request(1, 32'h14, 8);
        send_request(1, 32'h15, 9);
        send_request(1, 32'hFFFF_FFFF, 10);
        // Hold off until the cache has answered everything
        drain();
        write_capacity(0);
        send_request(1, 32'h20, 1);
        send_request(1, 32'h21, 2);
        send_request(1, 32'h20, 3);
        send_request(0, 32'h21, 0);
        drain();
        write_capacity(31);
        random_phase(500, 40);
        drain();
        write_capacity(5);
        random_phase(500, 12);
        busy_free = 1;
        random_phase(150, 12);
        busy_free = 0;
        drain();
        write_capacity(1);
        random_phase(250, 4);
        drain();
        write_capacity(16);
        random_phase(400, 30);
        drain();

        $display("Sent %0d requests, checked %0d responses (%0d hits, %0d evictions)",
                 sent, sb.checked, sb.hits_seen, sb.evicts_seen);
        if (sb.fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
